// ----- design/rdc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants and types of the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

    localparam int DIGIT_BITS = 8;

    localparam logic [DIGIT_BITS-1:0] RADIX_RESET = 8'd2;
    localparam logic [DIGIT_BITS-1:0] RADIX_MIN   = 8'd2;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctrl;

endpackage

// ----- design/rdc_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_divider
// Bit-serial restoring divider: dividend by an 8-bit base, one quotient bit
// per cycle, remainder and quotient-nonzero flag at the end.
// ----------------------------------------------------------------------------
module rdc_divider #(
    parameter int VALUE_BITS = 31
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic                           i_first,
    input  logic [VALUE_BITS-1:0]          i_value,
    input  logic [rdc_pkg::DIGIT_BITS-1:0] i_base,
    output logic                           o_done,
    output logic [rdc_pkg::DIGIT_BITS-1:0] o_rem,
    output logic                           o_nonzero
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_W-1:0]               r_cnt;
    logic [VALUE_BITS-1:0]          r_quo;
    logic [rdc_pkg::DIGIT_BITS-1:0] r_rem;
    logic                           r_nz;

    logic [rdc_pkg::DIGIT_BITS:0]   w_trial;
    logic [rdc_pkg::DIGIT_BITS:0]   w_diff;
    logic                           w_ge;
    logic [rdc_pkg::DIGIT_BITS-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[VALUE_BITS-1]};
        w_diff  = w_trial - {1'b0, i_base};
        w_ge    = (w_trial >= {1'b0, i_base});
        // partial remainder stays below the base, so it fits in a digit
        n_rem   = w_ge ? w_diff[rdc_pkg::DIGIT_BITS-1:0] : w_trial[rdc_pkg::DIGIT_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            // next division works on the previous quotient unless a new value starts
            if (i_first) begin
                r_quo <= i_value;
            end
            r_rem <= '0;
            r_nz  <= 1'b0;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], w_ge};
            r_rem <= n_rem;
            r_nz  <= r_nz | w_ge;
        end
    end

    assign o_done    = r_done;
    assign o_rem     = r_rem;
    assign o_nonzero = r_nz;

endmodule

// ----- design/rdc_digit_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_digit_stack
// Shift-register digit stack: push shifts in at the top, pop shifts down.
// When full the oldest digit falls off the bottom end.
// ----------------------------------------------------------------------------
module rdc_digit_stack #(
    parameter int DEPTH = 31
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rdc_pkg::t_stack_ctrl           i_ctrl,
    input  logic [rdc_pkg::DIGIT_BITS-1:0] i_digit,
    output logic [rdc_pkg::DIGIT_BITS-1:0] o_top,
    output logic                           o_single
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [rdc_pkg::DIGIT_BITS-1:0] r_stk [DEPTH];
    logic [CNT_W-1:0]               r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.push) begin
            // saturates: the window keeps the most recent digits
            if (r_count != CNT_W'(DEPTH)) begin
                r_count <= r_count + 1'b1;
            end
        end else if (i_ctrl.pop) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_stk[0] <= i_digit;
            for (int i = 1; i < DEPTH; i++) begin
                r_stk[i] <= r_stk[i-1];
            end
        end else if (i_ctrl.pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_stk[i] <= r_stk[i+1];
            end
        end
    end

    assign o_top    = r_stk[0];
    assign o_single = (r_count == CNT_W'(1));

endmodule

// ----- design/radix_digit_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts a non-negative integer into its digits in a programmable radix,
// most significant digit first, by repeated bit-serial division.
// ----------------------------------------------------------------------------
// Usage
//   Configuration: i_cfg_we writes i_cfg_radix into the radix register
//   (reset value 2). A radix of 0 or 1 is taken as 2. Write only while idle.
//   Input: a transaction is taken at a clock edge with start high and busy
//   low; i_value is sampled there and busy stays high until the last digit
//   has been issued.
//   Output: each digit appears on o_digit for one cycle with o_valid high;
//   o_last marks the least significant digit. The receiver cannot stall.
//   Timing: each digit comes from the serial divider at one quotient bit
//   per cycle. The digits of a value are divided one after another, then
//   popped from the stack through the output register and shown at one
//   digit per cycle; busy drops with the last digit, so the next
//   transaction may start in the cycle in which o_last is shown.
//   More digits than MAX_DIGITS: the least significant ones are dropped.
//   Reset: synchronous, clears the control state and sets the radix to 2.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 31
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rdc_pkg::DIGIT_BITS-1:0] i_cfg_radix,
    input  logic                           start,
    output logic                           busy,
    input  logic [VALUE_BITS-1:0]          i_value,
    output logic                           o_valid,
    output logic [rdc_pkg::DIGIT_BITS-1:0] o_digit,
    output logic                           o_last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic [rdc_pkg::DIGIT_BITS-1:0] r_radix;
    logic [rdc_pkg::DIGIT_BITS-1:0] r_base;
    logic                           r_valid;
    logic [rdc_pkg::DIGIT_BITS-1:0] r_digit;
    logic                           r_last;

    logic                           w_div_load;
    logic                           w_div_first;
    logic                           w_div_done;
    logic [rdc_pkg::DIGIT_BITS-1:0] w_div_rem;
    logic                           w_div_nz;
    rdc_pkg::t_stack_ctrl           w_stk_ctrl;
    logic [rdc_pkg::DIGIT_BITS-1:0] w_stk_top;
    logic                           w_stk_single;

    rdc_divider #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_div_load),
        .i_first  (w_div_first),
        .i_value  (i_value),
        .i_base   (r_base),
        .o_done   (w_div_done),
        .o_rem    (w_div_rem),
        .o_nonzero(w_div_nz)
    );

    rdc_digit_stack #(
        .DEPTH(MAX_DIGITS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_stk_ctrl),
        .i_digit (w_div_rem),
        .o_top   (w_stk_top),
        .o_single(w_stk_single)
    );

    always_comb begin
        n_state         = r_state;
        w_div_load      = 1'b0;
        w_div_first     = 1'b0;
        w_stk_ctrl.push = 1'b0;
        w_stk_ctrl.pop  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_div_load  = 1'b1;
                    w_div_first = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_stk_ctrl.push = 1'b1;
                    // quotient still nonzero: divide it again straight away
                    if (w_div_nz) begin
                        w_div_load = 1'b1;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                w_stk_ctrl.pop = 1'b1;
                if (w_stk_single) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_radix <= rdc_pkg::RADIX_RESET;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_EMIT);
            if (i_cfg_we) begin
                r_radix <= i_cfg_radix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_base <= (r_radix < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN : r_radix;
        end
        if (r_state == S_EMIT) begin
            r_digit <= w_stk_top;
            r_last  <= w_stk_single;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_digit = r_digit;
    assign o_last  = r_last;

    a_emit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |=> o_valid)
        else $error("digit not issued after an output cycle");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("digit issued after the last digit of a transaction");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the division phase");

    a_stack_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_stk_ctrl.push && w_stk_ctrl.pop))
        else $error("digit stack pushed and popped together");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_stk_ctrl.push && !w_stk_ctrl.pop)
        else $error("digit stack moved while idle");

endmodule

// ----- test/radix_digit_converter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_tb
// Drives values through the converter at several radix settings, including
// the extremes and the below-two cases. A directed table comes first, then
// random phases. Every digit is checked against the typed digits of its row
// or, where none are typed, against a behavioural digit stack in the bench.
// ----------------------------------------------------------------------------
module radix_digit_converter_tb;

    localparam int          VALUE_BITS   = 31;
    localparam int          N_DIRECTED   = 24;
    localparam int          N_PHASES     = 6;
    localparam int          PHASE_ITEMS  = 21;
    localparam int          IDLE_PERCENT = 7;
    localparam int          DRAIN_CYCLES = 40;
    localparam longint      CYCLE_LIMIT  = 2_000_000;
    localparam longint      VALUE_MAX    = (64'd1 << VALUE_BITS) - 1;

    typedef struct packed {
        logic [rdc_pkg::DIGIT_BITS-1:0] digit;
        logic                           last;
    } t_digit_result;

    // typed digits are listed most significant first; zero typed means predicted
    typedef struct packed {
        logic                                set_radix;
        logic [rdc_pkg::DIGIT_BITS-1:0]      radix;
        logic [VALUE_BITS-1:0]               value;
        logic [2:0]                          n_typed;
        logic [0:3][rdc_pkg::DIGIT_BITS-1:0] typed;
    } t_conv_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [rdc_pkg::DIGIT_BITS-1:0] i_cfg_radix;
    logic                           start;
    logic                           busy;
    logic [VALUE_BITS-1:0]          i_value;
    logic                           o_valid;
    logic [rdc_pkg::DIGIT_BITS-1:0] o_digit;
    logic                           o_last;

    t_digit_result                  digits_due[$];
    t_digit_result                  due_now;
    t_conv_row                      directed_rows [N_DIRECTED];
    logic [rdc_pkg::DIGIT_BITS-1:0] conv_radix;
    int                             digit_errors;
    longint                         cycle_count;

    radix_digit_converter #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (31)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_radix (i_cfg_radix),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_digit     (o_digit),
        .o_last      (o_last)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic int unsigned effective_radix();
        // radix 0 and 1 fall back to binary
        return 32'((conv_radix < rdc_pkg::RADIX_MIN) ? rdc_pkg::RADIX_MIN : conv_radix);
    endfunction

    // repeated division, remainders stacked least significant first
    function automatic void convert_to_digits(input logic [VALUE_BITS-1:0] value);
        logic [rdc_pkg::DIGIT_BITS-1:0] stack [VALUE_BITS];
        logic [VALUE_BITS-1:0]          quot;
        logic [VALUE_BITS-1:0]          base;
        int                             n;
        int                             k;
        base = VALUE_BITS'(effective_radix());
        quot = value;
        n    = 0;
        do begin
            stack[n] = rdc_pkg::DIGIT_BITS'(quot % base);
            quot     = quot / base;
            n++;
        end while (quot != 0);
        for (k = n - 1; k >= 0; k--) begin
            digits_due.push_back({stack[k], (k == 0)});
        end
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value(input int unsigned base);
        longint unsigned p;
        int              k;
        case ($urandom_range(0, 4))
            0: begin
                return VALUE_BITS'($urandom);
            end
            1: begin
                return VALUE_BITS'($urandom_range(0, base - 1));
            end
            2: begin
                return VALUE_BITS'($urandom >> $urandom_range(1, 31));
            end
            3: begin
                return $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
                // a power of the radix or one below it, to hit digit-count boundaries
                p = 1;
                k = $urandom_range(1, VALUE_BITS);
                while (k > 0 && p * base <= VALUE_MAX) begin
                    p = p * base;
                    k--;
                end
                return VALUE_BITS'(p - $urandom_range(0, 1));
            end
        endcase
    endfunction

    // only written once every digit of the previous transactions has been seen
    task automatic write_radix(input logic [rdc_pkg::DIGIT_BITS-1:0] radix);
        @(negedge i_clk);
        start = 1'b0;
        while (digits_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_radix = radix;
        conv_radix  = radix;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_radix = rdc_pkg::DIGIT_BITS'($urandom);
    endtask

    task automatic send_value(input logic [VALUE_BITS-1:0] value, input bit idle_ok,
                              input logic [2:0] n_typed,
                              input logic [0:3][rdc_pkg::DIGIT_BITS-1:0] typed);
        int k;
        @(negedge i_clk);
        while (idle_ok && $urandom_range(0, 99) < IDLE_PERCENT) begin
            start   = 1'b0;
            i_value = VALUE_BITS'($urandom);
            @(negedge i_clk);
        end
        start   = 1'b1;
        i_value = value;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        if (n_typed == 0) begin
            convert_to_digits(value);
        end else begin
            for (k = 0; k < n_typed; k++) begin
                digits_due.push_back({typed[k], (k == n_typed - 1)});
            end
        end
    endtask

    // results cannot be held off, so every strobe is checked as the next expected digit
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            if (digits_due.size() == 0) begin
                $error("unexpected digit %0d with last %0b", o_digit, o_last);
                digit_errors++;
            end else begin
                due_now = digits_due.pop_front();
                if (o_digit !== due_now.digit) begin
                    $error("digit: expected %0d, got %0d", due_now.digit, o_digit);
                    digit_errors++;
                end
                if (o_last !== due_now.last) begin
                    $error("last: expected %0b, got %0b", due_now.last, o_last);
                    digit_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL radix_digit_converter");
            $finish;
        end
    end

    initial begin
        int          r;
        int          phase;
        int          item;
        bit          idle_ok;
        int unsigned base;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_radix  = '0;
        start        = 1'b0;
        i_value      = '0;
        conv_radix   = rdc_pkg::RADIX_RESET;
        digit_errors = 0;
        cycle_count  = 0;

        //                    set   radix   value           n     typed digits
        directed_rows[0]  = {1'b0, 8'd2,   31'd6,          3'd3, 8'd1, 8'd1, 8'd0, 8'd0};
        directed_rows[1]  = {1'b0, 8'd2,   31'd0,          3'd1, 8'd0, 8'd0, 8'd0, 8'd0};
        directed_rows[2]  = {1'b0, 8'd2,   31'd1,          3'd1, 8'd1, 8'd0, 8'd0, 8'd0};
        directed_rows[3]  = {1'b0, 8'd2,   31'h7FFF_FFFF,  3'd0, 32'd0};
        directed_rows[4]  = {1'b0, 8'd2,   31'h5555_5555,  3'd0, 32'd0};
        directed_rows[5]  = {1'b1, 8'd10,  31'd0,          3'd1, 8'd0, 8'd0, 8'd0, 8'd0};
        directed_rows[6]  = {1'b0, 8'd10,  31'd9,          3'd1, 8'd9, 8'd0, 8'd0, 8'd0};
        directed_rows[7]  = {1'b0, 8'd10,  31'd10,         3'd2, 8'd1, 8'd0, 8'd0, 8'd0};
        directed_rows[8]  = {1'b0, 8'd10,  31'd1234,       3'd4, 8'd1, 8'd2, 8'd3, 8'd4};
        directed_rows[9]  = {1'b0, 8'd10,  31'h7FFF_FFFF,  3'd0, 32'd0};
        directed_rows[10] = {1'b1, 8'd16,  31'h0ABC,       3'd3, 8'd10, 8'd11, 8'd12, 8'd0};
        directed_rows[11] = {1'b0, 8'd16,  31'h2AAA_AAAA,  3'd0, 32'd0};
        directed_rows[12] = {1'b1, 8'd255, 31'd254,        3'd1, 8'd254, 8'd0, 8'd0, 8'd0};
        directed_rows[13] = {1'b0, 8'd255, 31'd255,        3'd2, 8'd1, 8'd0, 8'd0, 8'd0};
        directed_rows[14] = {1'b0, 8'd255, 31'h7FFF_FFFF,  3'd0, 32'd0};
        directed_rows[15] = {1'b0, 8'd255, 31'd0,          3'd1, 8'd0, 8'd0, 8'd0, 8'd0};
        directed_rows[16] = {1'b1, 8'd0,   31'd5,          3'd3, 8'd1, 8'd0, 8'd1, 8'd0};
        directed_rows[17] = {1'b0, 8'd0,   31'h7FFF_FFFF,  3'd0, 32'd0};
        directed_rows[18] = {1'b1, 8'd1,   31'd2,          3'd2, 8'd1, 8'd0, 8'd0, 8'd0};
        directed_rows[19] = {1'b0, 8'd1,   31'd1,          3'd1, 8'd1, 8'd0, 8'd0, 8'd0};
        directed_rows[20] = {1'b1, 8'd3,   31'd8,          3'd2, 8'd2, 8'd2, 8'd0, 8'd0};
        directed_rows[21] = {1'b1, 8'd128, 31'h4000_0000,  3'd0, 32'd0};
        directed_rows[22] = {1'b0, 8'd128, 31'd127,        3'd1, 8'd127, 8'd0, 8'd0, 8'd0};
        directed_rows[23] = {1'b1, 8'd254, 31'd253,        3'd1, 8'd253, 8'd0, 8'd0, 8'd0};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (r = 0; r < N_DIRECTED; r++) begin
            if (directed_rows[r].set_radix) begin
                write_radix(directed_rows[r].radix);
            end
            send_value(directed_rows[r].value, 1'b1, directed_rows[r].n_typed,
                       directed_rows[r].typed);
        end

        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0:       write_radix(8'd255);
                1:       write_radix(8'd0);
                2:       write_radix(8'd16);
                3:       write_radix(8'd1);
                default: write_radix(rdc_pkg::DIGIT_BITS'($urandom_range(0, 255)));
            endcase
            base    = effective_radix();
            // one phase runs back to back with no gaps from the sender
            idle_ok = (phase != 2);
            for (item = 0; item < PHASE_ITEMS; item++) begin
                send_value(pick_value(base), idle_ok, 3'd0, '0);
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (digits_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (digit_errors == 0 && digits_due.size() == 0) begin
            $display("PASS radix_digit_converter");
        end else begin
            $display("FAIL radix_digit_converter");
        end
        $finish;
    end

endmodule
